/* design/bps_pkg.sv */
// Shared types and constants of the bucketed priority stack.
`default_nettype none
package bps_pkg;

  localparam int LEVELS      = 16;
  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CAPACITY    = LEVELS * STACK_DEPTH;

  localparam int LEVEL_W  = $clog2(LEVELS);
  localparam int IDX_W    = $clog2(STACK_DEPTH);
  localparam int HEIGHT_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 16;
  localparam int VALUE_W  = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    op_e                       op;
    logic [VALUE_W-1:0]        value;
    logic signed [PRIO_W-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic                item_valid;
    logic [VALUE_W-1:0]  item_value;
    status_e             status;
    logic [COUNT_W-1:0]  removed_count;
    logic [COUNT_W-1:0]  occupancy;
  } rsp_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LEVEL_W-1:0] lv,
                                                input logic [HEIGHT_W-1:0] idx);
    addr_of = ADDR_W'(ADDR_W'(lv) * ADDR_W'(STACK_DEPTH)) + ADDR_W'(idx);
  endfunction

endpackage
`default_nettype wire

/* design/bucketed_priority_stack.sv */
// Top level of the bucketed priority stack: one LIFO stack per priority level.
//
// Requests are taken one at a time. Push, clear, an empty pop and a flush whose
// threshold lies at or above the last level complete in the idle state. A pop
// that finds an item passes through the S_POP_RD state for the stack memory read.
// A flush whose threshold lies below the last level sweeps the levels one at a
// time, from the level after the threshold up to the last level, whether or not
// those levels hold items. The result sits in an output register, so a new
// request is taken while the previous result still waits; a result that finds
// that register full waits until it drains, and requests stall meanwhile. Item
// payloads live in a 256-entry one-port-write, one-port-read memory; per-level
// heights are kept in flops next to it.
`default_nettype none
module bucketed_priority_stack (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic signed [bps_pkg::PRIO_W-1:0]   cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire bps_pkg::req_t                       in_req_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output bps_pkg::rsp_t                            out_rsp_o
);

  localparam int LW = bps_pkg::LEVEL_W;
  localparam int HW = bps_pkg::HEIGHT_W;
  localparam int CW = bps_pkg::COUNT_W;
  localparam int EW = bps_pkg::PRIO_W + 1;
  localparam int FW = bps_pkg::PRIO_W + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_FLUSH,
    S_EMIT
  } state_e;

  state_e                         state_q, state_d;
  logic signed [bps_pkg::PRIO_W-1:0] base_q;
  logic [HW-1:0]                  heights_q [bps_pkg::LEVELS];
  logic [CW-1:0]                  total_q, total_d;
  logic [LW-1:0]                  start_q, start_d;
  logic [LW-1:0]                  scan_q, scan_d;
  logic [CW-1:0]                  rem_q, rem_d;
  bps_pkg::rsp_t                  res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  bps_pkg::rsp_t                  out_rsp_q, out_rsp_d;

  logic                           accept;
  logic signed [EW-1:0]           level_s;
  logic signed [FW-1:0]           first_s;
  logic                           push_in_range;
  logic                           flush_do;
  logic [LW-1:0]                  flush_from;
  logic [bps_pkg::LEVELS-1:0]     nonempty;
  logic                           found;
  logic [LW-1:0]                  found_lv;
  logic [LW-1:0]                  h_idx;
  logic [HW-1:0]                  h_rd;
  logic                           h_we;
  logic [HW-1:0]                  h_wdata;
  logic                           clear_all;
  logic [CW-1:0]                  rem_sum;
  logic                           fin_valid;
  bps_pkg::rsp_t                  fin_rsp;
  logic                           slot_free;

  logic                              ram_we, ram_re;
  logic [bps_pkg::ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [bps_pkg::DATA_WIDTH-1:0]    ram_rdata;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign level_s = {in_req_i.priority_req[bps_pkg::PRIO_W-1], in_req_i.priority_req}
                 - {base_q[bps_pkg::PRIO_W-1], base_q};
  assign first_s = {level_s[EW-1], level_s} + FW'(1);
  assign push_in_range = !level_s[EW-1] && (level_s < $signed(EW'(bps_pkg::LEVELS)));
  assign flush_do      = first_s < $signed(FW'(bps_pkg::LEVELS));
  assign flush_from    = first_s[FW-1] ? '0 : LW'(first_s);

  always_comb begin
    for (int i = 0; i < bps_pkg::LEVELS; i++) begin
      nonempty[i] = (heights_q[i] != '0);
    end
  end

  always_comb begin
    found    = 1'b0;
    found_lv = '0;
    for (int i = bps_pkg::LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i] && (LW'(i) >= start_q)) begin
        found    = 1'b1;
        found_lv = LW'(i);
      end
    end
  end

  always_comb begin
    if (state_q == S_FLUSH) begin
      h_idx = scan_q;
    end else if (in_req_i.op == bps_pkg::OP_PUSH) begin
      h_idx = LW'(level_s);
    end else begin
      h_idx = found_lv;
    end
  end

  assign h_rd    = heights_q[h_idx];
  assign rem_sum = rem_q + CW'(h_rd);

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    start_d     = start_q;
    scan_d      = scan_q;
    rem_d       = rem_q;
    res_d       = res_q;
    h_we        = 1'b0;
    h_wdata     = '0;
    clear_all   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = bps_pkg::addr_of(h_idx, h_rd);
    ram_re      = 1'b0;
    ram_raddr   = bps_pkg::addr_of(h_idx, h_rd - HW'(1));
    fin_valid   = 1'b0;
    fin_rsp     = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_req_i.op)
            bps_pkg::OP_PUSH: begin
              fin_valid = 1'b1;
              if (!push_in_range) begin
                fin_rsp.status = bps_pkg::ST_RANGE;
              end else if (h_rd == HW'(bps_pkg::STACK_DEPTH)) begin
                fin_rsp.status = bps_pkg::ST_FULL;
              end else begin
                ram_we  = 1'b1;
                h_we    = 1'b1;
                h_wdata = h_rd + HW'(1);
                total_d = total_q + CW'(1);
                if (h_idx < start_q) begin
                  start_d = h_idx;
                end
              end
            end
            bps_pkg::OP_POP: begin
              if ((total_q != '0) && found) begin
                ram_re  = 1'b1;
                h_we    = 1'b1;
                h_wdata = h_rd - HW'(1);
                total_d = total_q - CW'(1);
                start_d = found_lv;
                state_d = S_POP_RD;
              end else begin
                fin_valid      = 1'b1;
                fin_rsp.status = bps_pkg::ST_EMPTY;
              end
            end
            bps_pkg::OP_FLUSH: begin
              if (flush_do) begin
                scan_d  = flush_from;
                rem_d   = '0;
                state_d = S_FLUSH;
                if (start_q >= flush_from) begin
                  start_d = LW'(bps_pkg::LEVELS - 1);
                end
              end else begin
                fin_valid = 1'b1;
              end
            end
            default: begin
              clear_all = 1'b1;
              total_d   = '0;
              start_d   = LW'(bps_pkg::LEVELS - 1);
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP_RD: begin
        fin_valid          = 1'b1;
        fin_rsp.item_valid = 1'b1;
        fin_rsp.item_value = bps_pkg::VALUE_W'(ram_rdata);
      end
      S_FLUSH: begin
        h_we    = 1'b1;
        h_wdata = '0;
        rem_d   = rem_sum;
        if (scan_q == LW'(bps_pkg::LEVELS - 1)) begin
          total_d               = total_q - rem_sum;
          fin_valid             = 1'b1;
          fin_rsp.removed_count = rem_sum;
        end else begin
          scan_d = scan_q + LW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    fin_rsp.occupancy = total_d;

    if (fin_valid) begin
      if (slot_free) begin
        out_valid_d = 1'b1;
        out_rsp_d   = fin_rsp;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_rsp;
        state_d = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      total_q     <= '0;
      start_q     <= LW'(bps_pkg::LEVELS - 1);
      scan_q      <= '0;
      rem_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
      for (int i = 0; i < bps_pkg::LEVELS; i++) begin
        heights_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      start_q     <= start_d;
      scan_q      <= scan_d;
      rem_q       <= rem_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (clear_all) begin
        for (int i = 0; i < bps_pkg::LEVELS; i++) begin
          heights_q[i] <= '0;
        end
      end else if (h_we) begin
        heights_q[h_idx] <= h_wdata;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  bps_ram #(
    .DEPTH  (bps_pkg::CAPACITY),
    .WIDTH  (bps_pkg::DATA_WIDTH),
    .ADDR_W (bps_pkg::ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_req_i.value[bps_pkg::DATA_WIDTH-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_start_is_lowest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      ((nonempty & ((bps_pkg::LEVELS)'(1) << start_q) - (bps_pkg::LEVELS)'(1)) == '0))
    else $error("nonempty level below start level");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(bps_pkg::CAPACITY))
    else $error("item count exceeds capacity");

  a_pop_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> !ram_we ##1 (state_q == S_POP_RD))
    else $error("stack read not followed by pop completion");

endmodule
`default_nettype wire

/* design/bps_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module bps_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* tb/sv/bucketed_priority_stack_check.sv */
// Scoreboard for the bucketed priority stack: mirrors the stacks and scores every response.
`timescale 1ns / 1ps
module bucketed_priority_stack_check
  import bps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic signed [PRIO_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  req_t                     in_req_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  rsp_t                     out_rsp_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       responses_o
);

  logic [DATA_WIDTH-1:0]    slot_value [CAPACITY];
  logic [HEIGHT_W-1:0]      depth_of [LEVELS];
  logic [COUNT_W-1:0]       held;
  logic [LEVEL_W-1:0]       top_level;
  logic signed [PRIO_W-1:0] base;
  rsp_t                     replies_due [$];

  function automatic rsp_t run_stack_op(input req_t r);
    rsp_t               o;
    int                 lvl;
    int                 lv;
    int                 first;
    int                 from;
    logic [COUNT_W-1:0] gone;
    o = '0;
    o.status = ST_OK;
    lvl = int'(r.priority_req) - int'(base);
    case (r.op)
      OP_PUSH: begin
        if (lvl < 0 || lvl >= LEVELS) begin
          o.status = ST_RANGE;
        end else if (depth_of[lvl] >= STACK_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          slot_value[lvl * STACK_DEPTH + int'(depth_of[lvl])] = r.value[DATA_WIDTH-1:0];
          depth_of[lvl] = depth_of[lvl] + 1'b1;
          held = held + 1'b1;
          if (lvl < int'(top_level)) top_level = LEVEL_W'(lvl);
        end
      end
      OP_POP: begin
        o.status = ST_EMPTY;
        if (held != 0) begin
          lv = int'(top_level);
          while (lv < LEVELS && depth_of[lv] == 0) lv++;
          if (lv < LEVELS) begin
            depth_of[lv] = depth_of[lv] - 1'b1;
            o.item_value = slot_value[lv * STACK_DEPTH + int'(depth_of[lv])];
            o.item_valid = 1'b1;
            o.status = ST_OK;
            held = held - 1'b1;
            top_level = LEVEL_W'(lv);
          end
        end
      end
      OP_FLUSH: begin
        first = lvl + 1;
        if (first < LEVELS) begin
          from = (first < 0) ? 0 : first;
          gone = '0;
          for (lv = from; lv < LEVELS; lv++) begin
            gone = gone + depth_of[lv];
            depth_of[lv] = '0;
          end
          held = held - gone;
          if (int'(top_level) >= from) top_level = LEVEL_W'(LEVELS - 1);
          o.removed_count = gone;
        end
      end
      default: begin
        foreach (depth_of[i]) depth_of[i] = '0;
        held = '0;
        top_level = LEVEL_W'(LEVELS - 1);
      end
    endcase
    o.occupancy = held;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      foreach (depth_of[i]) depth_of[i] = '0;
      held = '0;
      top_level = LEVEL_W'(LEVELS - 1);
      base = '0;
      replies_due.delete();
      errors_o = 0;
      pending_o = 0;
      responses_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        responses_o = responses_o + 1;
        if (replies_due.size() == 0) begin
          errors_o = errors_o + 1;
          if (errors_o <= 10)
            $display("response with no request outstanding: valid %0b value %h status %0d",
                     out_rsp_i.item_valid, out_rsp_i.item_value, out_rsp_i.status);
        end else begin
          want = replies_due.pop_front();
          if (out_rsp_i.item_valid !== want.item_valid ||
              out_rsp_i.item_value !== want.item_value ||
              out_rsp_i.status !== want.status ||
              out_rsp_i.removed_count !== want.removed_count ||
              out_rsp_i.occupancy !== want.occupancy) begin
            errors_o = errors_o + 1;
            if (errors_o <= 10)
              $display({"response %0d mismatch (exp/got): valid %0b/%0b value %h/%h ",
                        "status %0d/%0d removed %0d/%0d occupancy %0d/%0d"},
                       responses_o, want.item_valid, out_rsp_i.item_valid,
                       want.item_value, out_rsp_i.item_value,
                       want.status, out_rsp_i.status,
                       want.removed_count, out_rsp_i.removed_count,
                       want.occupancy, out_rsp_i.occupancy);
          end
        end
      end
      if (cfg_we_i) base = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) replies_due.push_back(run_stack_op(in_req_i));
      pending_o = replies_due.size();
    end
  end

endmodule

/* tb/sv/bucketed_priority_stack_test.sv */
// Top of the bucketed priority stack testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module bucketed_priority_stack_test;
  import bps_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_REQS   = 330;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic signed [PRIO_W-1:0] cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  req_t                     in_req = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  rsp_t                     out_rsp;

  int errors;
  int pending;
  int responses;
  int cycles = 0;
  bit gaps_on = 1'b1;
  int n_push = 0;
  int n_pop = 0;
  int n_flush = 0;
  int n_clear = 0;
  int n_bases = 0;

  bucketed_priority_stack i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  bucketed_priority_stack_check i_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .errors_o    (errors),
    .pending_o   (pending),
    .responses_o (responses)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bucketed_priority_stack verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 21);
  end

  function automatic req_t mk(input op_e op, input logic [VALUE_W-1:0] v, input int prio);
    req_t r;
    r.op = op;
    r.value = v;
    r.priority_req = PRIO_W'(prio);
    return r;
  endfunction

  function automatic req_t rand_req(input int base_v, input int lo, input int hi,
                                    input int push_pct, input int pop_pct);
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < push_pct) begin
      r.op = OP_PUSH;
    end else if (pick < push_pct + pop_pct) begin
      r.op = OP_POP;
    end else if (pick < 98) begin
      r.op = OP_FLUSH;
    end else begin
      r.op = OP_CLEAR;
    end
    r.value = $urandom;
    // mostly inside the level window, one step past each edge, plus raw noise
    if ($urandom_range(99) < 6) begin
      r.priority_req = PRIO_W'($urandom);
    end else begin
      r.priority_req = PRIO_W'(base_v + lo - 1 + int'($urandom_range(hi - lo + 2)));
    end
    return r;
  endfunction

  task automatic send(input req_t r);
    while (gaps_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (r.op)
      OP_PUSH:  n_push++;
      OP_POP:   n_pop++;
      OP_FLUSH: n_flush++;
      default:  n_clear++;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_base(input int v);
    settle();
    cfg_wdata <= PRIO_W'(v);
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_bases++;
  endtask

  task automatic run_phase(input int base_v, input int lo, input int hi,
                           input int push_pct, input int pop_pct);
    set_base(base_v);
    for (int i = 0; i < PHASE_REQS; i++) begin
      send(rand_req(base_v, lo, hi, push_pct, pop_pct));
      if (i == PHASE_REQS / 2) settle();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, priority_base still at reset value
    send(mk(OP_POP,   32'h0, 0));
    send(mk(OP_PUSH,  32'h0000_0000, 0));
    send(mk(OP_PUSH,  32'hFFFF_FFFF, LEVELS - 1));
    send(mk(OP_PUSH,  32'h1234_5678, -1));
    send(mk(OP_PUSH,  32'h1234_5678, LEVELS));
    send(mk(OP_PUSH,  32'h1, 32767));
    send(mk(OP_PUSH,  32'h2, -32768));
    send(mk(OP_PUSH,  32'hA5A5_5A5A, 7));
    send(mk(OP_PUSH,  32'h5A5A_A5A5, 7));
    send(mk(OP_POP,   32'h0, 0));
    send(mk(OP_POP,   32'h0, 0));
    send(mk(OP_FLUSH, 32'h0, 5));
    send(mk(OP_PUSH,  32'hDEAD_BEEF, 10));
    send(mk(OP_FLUSH, 32'h0, LEVELS - 1));
    send(mk(OP_FLUSH, 32'h0, -1));
    send(mk(OP_PUSH,  32'hCAFE_F00D, 2));
    send(mk(OP_PUSH,  32'h0BAD_F00D, 3));
    send(mk(OP_FLUSH, 32'h0, -32768));
    send(mk(OP_PUSH,  32'h7777_7777, 4));
    send(mk(OP_CLEAR, 32'h0, 0));
    send(mk(OP_POP,   32'h0, 0));

    run_phase(0, 0, LEVELS - 1, 55, 30);
    run_phase(-32768, 0, 2, 68, 18);
    run_phase(32767, 0, LEVELS - 1, 55, 30);
    gaps_on = 1'b0;
    run_phase(int'($urandom_range(2000)) - 1000, 5, 9, 60, 25);
    gaps_on = 1'b1;
    run_phase(-7, 0, LEVELS - 1, 50, 35);

    settle();
    $display("sent %0d requests (%0d push, %0d pop, %0d flush, %0d clear)",
             n_push + n_pop + n_flush + n_clear, n_push, n_pop, n_flush, n_clear);
    $display("scored %0d responses across %0d priority_base settings, %0d mismatches",
             responses, n_bases, errors);
    if (errors == 0 && pending == 0) begin
      $display("bucketed_priority_stack verification clean");
    end else begin
      $display("bucketed_priority_stack verification failed");
    end
    $finish;
  end

endmodule
